// ===== rtl/core/triple_click_gesture_classifier_defines.svh =====
// Assertion macros for the triple-click gesture classifier.
// Used by the top level under rtl/core; needs signals clk and rst in scope.
`ifndef TRIPLE_CLICK_GESTURE_CLASSIFIER_DEFINES_SVH
`define TRIPLE_CLICK_GESTURE_CLASSIFIER_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define TCGC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define TCGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tcgc_pkg.sv =====
// Package for the triple-click gesture classifier: widths, codes, reset values.
// No dependencies; used by the channel interfaces and the top level.
package tcgc_pkg;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int COORD_W = 16;
  localparam int TIME_W  = 32;
  localparam int GEST_W  = 3;
  localparam int CNT_W   = 6;
  localparam int GAP_W   = 8;
  localparam int CLICK_W = 2;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 16;

  // Default sample window per axis
  localparam int SAMPLE_WINDOW_DEF = 35;

  // Event command codes
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POS_X = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POS_Y = 3'd4;

  // Gesture codes
  localparam logic [GEST_W-1:0] GEST_VERTICAL   = 3'd0;
  localparam logic [GEST_W-1:0] GEST_HORIZONTAL = 3'd1;
  localparam logic [GEST_W-1:0] GEST_RIGHT_DIAG = 3'd2;
  localparam logic [GEST_W-1:0] GEST_LEFT_DIAG  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_V_SHAPE    = 3'd4;

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_NARROW_SPAN = 2'd0;
  localparam logic [ADDR_W-1:0] REG_VERT_TRAVEL = 2'd1;
  localparam logic [ADDR_W-1:0] REG_CLICK_GAP   = 2'd2;

  // Register reset values
  localparam logic [COORD_W-1:0] NARROW_SPAN_RST = 16'd10000;
  localparam logic [COORD_W-1:0] VERT_TRAVEL_RST = 16'd3000;
  localparam logic [GAP_W-1:0]   CLICK_GAP_RST   = 8'd1;

  // Clicks that arm recording
  localparam logic [CLICK_W-1:0] CLICKS_TO_ARM = 2'd3;

endpackage

// ===== rtl/core/tcgc_evt_if.sv =====
// Pointer event channel: valid/ready handshake, one event per beat.
// Depends on tcgc_pkg.
interface tcgc_evt_if;
  import tcgc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] event_value;
  logic [TIME_W-1:0]  time_sec;

  modport source (output valid, command, event_value, time_sec, input ready);
  modport sink   (input valid, command, event_value, time_sec, output ready);
endinterface

// ===== rtl/core/tcgc_res_if.sv =====
// Gesture result channel: valid/ready handshake, one gesture per beat.
// Depends on tcgc_pkg.
interface tcgc_res_if;
  import tcgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [GEST_W-1:0] gesture;
  logic [CNT_W-1:0]  x_samples;
  logic [CNT_W-1:0]  y_samples;

  modport source (output valid, gesture, x_samples, y_samples, input ready);
  modport sink   (input valid, gesture, x_samples, y_samples, output ready);
endinterface

// ===== rtl/core/tcgc_cfg_if.sv =====
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on tcgc_pkg.
interface tcgc_cfg_if;
  import tcgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/triple_click_gesture_classifier.sv =====
// Triple-click gesture classifier, top level.
// Depends on tcgc_pkg, the tcgc_*_if channel interfaces and the assertion macro header.
//
// Takes one pointer event per clock while evt.ready is high and updates its click
// and sampling state in the same cycle. Three left presses, each within
// click_gap_seconds of the last button event, arm recording; X/Y positions then
// feed running min/max, the first/second X and first/last Y samples, and the next
// button press emits one gesture beat. Results go through an output register backed
// by one skid slot, so events keep flowing while a result waits; evt.ready drops
// only when both slots hold results. An event that ends a gesture shows on res.valid
// in the cycle after its beat when the output register is free or handed off at
// that edge; otherwise it waits in the skid slot until the output register drains.
// Configuration writes are taken every cycle and should be made only while idle.
`include "triple_click_gesture_classifier_defines.svh"

module triple_click_gesture_classifier #(
  parameter int SAMPLE_WINDOW = tcgc_pkg::SAMPLE_WINDOW_DEF
) (
  input logic        clk,
  input logic        rst,
  tcgc_evt_if.sink   evt,
  tcgc_res_if.source res,
  tcgc_cfg_if.sink   cfg
);
  import tcgc_pkg::*;

  localparam logic [CNT_W-1:0] WIN = CNT_W'(SAMPLE_WINDOW);

  // Config registers
  logic [COORD_W-1:0] narrow_span_limit;
  logic [COORD_W-1:0] vertical_travel_limit;
  logic [GAP_W-1:0]   click_gap_seconds;

  // Gesture state
  logic [CLICK_W-1:0] click_count, click_count_next;
  logic               recording, recording_next;
  logic [TIME_W-1:0]  last_button_time, last_button_time_next;
  logic [CNT_W-1:0]   x_count, x_count_next;
  logic [CNT_W-1:0]   y_count, y_count_next;
  logic [COORD_W-1:0] low_x, low_x_next, high_x, high_x_next;
  logic [COORD_W-1:0] low_y, low_y_next, high_y, high_y_next;
  logic [COORD_W-1:0] first_x, first_x_next, second_x, second_x_next;
  logic [COORD_W-1:0] first_y, first_y_next, last_y, last_y_next;

  // Output slot and skid slot
  logic              out_valid, skid_valid;
  logic [GEST_W-1:0] out_gesture, skid_gesture;
  logic [CNT_W-1:0]  out_x, out_y, skid_x, skid_y;

  logic              evt_fire;
  logic              produce;
  logic              press;
  logic              gap_over;
  logic [GEST_W-1:0] gesture_now;
  logic [COORD_W-1:0] travel;
  logic              x_narrow, y_narrow;

  assign evt.ready = !skid_valid;
  assign evt_fire  = evt.valid && evt.ready;
  assign cfg.ready = 1'b1;
  assign press     = (evt.event_value != '0);
  assign gap_over  = (evt.time_sec - last_button_time) > TIME_W'(click_gap_seconds);

  // Classification from the current window
  assign travel   = (last_y >= first_y) ? (last_y - first_y) : (first_y - last_y);
  assign x_narrow = (high_x < low_x) || ((high_x - low_x) <= narrow_span_limit);
  assign y_narrow = (high_y < low_y) || ((high_y - low_y) <= narrow_span_limit);

  always_comb begin
    if (x_narrow && (travel > vertical_travel_limit)) begin
      gesture_now = GEST_VERTICAL;
    end else if (y_narrow) begin
      gesture_now = GEST_HORIZONTAL;
    end else if (travel < vertical_travel_limit) begin
      gesture_now = GEST_V_SHAPE;
    end else if (first_x < second_x) begin
      gesture_now = GEST_RIGHT_DIAG;
    end else begin
      gesture_now = GEST_LEFT_DIAG;
    end
  end

  // Next-state logic for one event beat
  always_comb begin
    click_count_next      = click_count;
    recording_next        = recording;
    last_button_time_next = last_button_time;
    x_count_next          = x_count;
    y_count_next          = y_count;
    low_x_next            = low_x;
    high_x_next           = high_x;
    low_y_next            = low_y;
    high_y_next           = high_y;
    first_x_next          = first_x;
    second_x_next         = second_x;
    first_y_next          = first_y;
    last_y_next           = last_y;
    produce               = 1'b0;

    if (evt_fire) begin
      unique case (evt.command) inside
        CMD_LEFT, CMD_RIGHT: begin
          // drop a stale partial sequence first
          if ((click_count != '0) && !recording && gap_over) begin
            click_count_next = '0;
          end
          if (press) begin
            if (recording) begin
              produce          = 1'b1;
              click_count_next = '0;
              recording_next   = 1'b0;
            end else if (evt.command == CMD_LEFT) begin
              click_count_next = click_count_next + CLICK_W'(1);
              if (click_count_next == CLICKS_TO_ARM) begin
                recording_next = 1'b1;
              end
            end else begin
              click_count_next = '0;
            end
            // arming or finishing starts a fresh window
            if (recording || recording_next) begin
              x_count_next = '0;
              y_count_next = '0;
              low_x_next   = '1;
              high_x_next  = '0;
              low_y_next   = '1;
              high_y_next  = '0;
            end
          end
          last_button_time_next = evt.time_sec;
        end
        CMD_KEY: begin
          if (!recording) begin
            click_count_next = '0;
          end
        end
        CMD_POS_X: begin
          if (recording && (x_count < WIN)) begin
            if (x_count == '0) begin
              first_x_next = evt.event_value;
            end else if (x_count == CNT_W'(1)) begin
              second_x_next = evt.event_value;
            end
            if (evt.event_value < low_x) low_x_next = evt.event_value;
            if (evt.event_value > high_x) high_x_next = evt.event_value;
            x_count_next = x_count + CNT_W'(1);
          end
        end
        CMD_POS_Y: begin
          if (recording) begin
            if (y_count < WIN) begin
              if (y_count == '0) begin
                first_y_next = evt.event_value;
              end
              if (evt.event_value < low_y) low_y_next = evt.event_value;
              if (evt.event_value > high_y) high_y_next = evt.event_value;
              y_count_next = y_count + CNT_W'(1);
            end
            last_y_next = evt.event_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Gesture state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      click_count      <= '0;
      recording        <= 1'b0;
      last_button_time <= '0;
      x_count          <= '0;
      y_count          <= '0;
      low_x            <= '1;
      high_x           <= '0;
      low_y            <= '1;
      high_y           <= '0;
      first_x          <= '0;
      second_x         <= '0;
      first_y          <= '0;
      last_y           <= '0;
    end else begin
      click_count      <= click_count_next;
      recording        <= recording_next;
      last_button_time <= last_button_time_next;
      x_count          <= x_count_next;
      y_count          <= y_count_next;
      low_x            <= low_x_next;
      high_x           <= high_x_next;
      low_y            <= low_y_next;
      high_y           <= high_y_next;
      first_x          <= first_x_next;
      second_x         <= second_x_next;
      first_y          <= first_y_next;
      last_y           <= last_y_next;
    end
  end

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_span_limit     <= NARROW_SPAN_RST;
      vertical_travel_limit <= VERT_TRAVEL_RST;
      click_gap_seconds     <= CLICK_GAP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_NARROW_SPAN: narrow_span_limit     <= cfg.data;
        REG_VERT_TRAVEL: vertical_travel_limit <= cfg.data;
        REG_CLICK_GAP:   click_gap_seconds     <= cfg.data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Output slot valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid  <= skid_valid || produce;
      skid_valid <= skid_valid && produce;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // Output slot payloads
  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_gesture <= skid_gesture;
        out_x       <= skid_x;
        out_y       <= skid_y;
        if (produce) begin
          skid_gesture <= gesture_now;
          skid_x       <= x_count;
          skid_y       <= y_count;
        end
      end else if (produce) begin
        out_gesture <= gesture_now;
        out_x       <= x_count;
        out_y       <= y_count;
      end
    end else if (produce) begin
      skid_gesture <= gesture_now;
      skid_x       <= x_count;
      skid_y       <= y_count;
    end
  end

  assign res.valid     = out_valid;
  assign res.gesture   = out_gesture;
  assign res.x_samples = out_x;
  assign res.y_samples = out_y;

  // Checks
  `TCGC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid || out_valid,
    "skid slot full while output slot empty")
  `TCGC_ASSERT_ALWAYS(a_rec_armed_count, !recording || (click_count == CLICKS_TO_ARM),
    "recording without a full click sequence")
  `TCGC_ASSERT_ALWAYS(a_idle_window_empty, recording || ((x_count == '0) && (y_count == '0)),
    "samples held while not recording")
  `TCGC_ASSERT_ALWAYS(a_count_bound, (x_count <= WIN) && (y_count <= WIN),
    "sample count past window")
  `TCGC_ASSERT_NEXT(a_result_lands, produce, res.valid,
    "finished gesture not presented")

endmodule

// ===== test/tb_triple_click_gesture_classifier.sv =====
`timescale 1ns / 100ps
// Testbench for the triple-click gesture classifier: drives pointer events and
// register writes, predicts every gesture beat and checks it field by field.
// Depends on tcgc_pkg, the tcgc_*_if channel interfaces and the classifier RTL.
module tb_triple_click_gesture_classifier;
  import tcgc_pkg::*;

  localparam int WINDOW = SAMPLE_WINDOW_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;  // no register behind it
  // Commands the block does not act on
  localparam logic [CMD_W-1:0] CMD_NONE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NONE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NONE_HI  = 3'd7;

  typedef struct packed {
    logic [GEST_W-1:0] gesture;
    logic [CNT_W-1:0]  x_samples;
    logic [CNT_W-1:0]  y_samples;
  } gesture_beat_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  tcgc_evt_if evt_ch();
  tcgc_res_if res_ch();
  tcgc_cfg_if cfg_ch();

  triple_click_gesture_classifier dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Predictor copy of registers and state
  logic [COORD_W-1:0] span_lim;
  logic [COORD_W-1:0] travel_lim;
  logic [GAP_W-1:0]   gap_lim;
  logic [CLICK_W-1:0] clicks;
  logic               armed;
  logic [TIME_W-1:0]  last_btn_t;
  logic [CNT_W-1:0]   x_cnt, y_cnt;
  logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [COORD_W-1:0] x_first, x_second, y_first, y_last;

  gesture_beat_t pending_gestures[$];
  int gesture_errors = 0;
  int events_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int holdoff_cycles_req = 0;
  int holdoff_done = 0;

  // Stimulus side: seconds clock and the coordinates of the current stroke
  logic [TIME_W-1:0]  now_t;
  logic [COORD_W-1:0] stroke_pts [2][48];

  function automatic void clear_window();
    x_cnt = '0;
    y_cnt = '0;
    lo_x  = '1;
    hi_x  = '0;
    lo_y  = '1;
    hi_y  = '0;
  endfunction

  function automatic void reset_model();
    span_lim   = NARROW_SPAN_RST;
    travel_lim = VERT_TRAVEL_RST;
    gap_lim    = CLICK_GAP_RST;
    clicks     = '0;
    armed      = 1'b0;
    last_btn_t = '0;
    x_first    = '0;
    x_second   = '0;
    y_first    = '0;
    y_last     = '0;
    clear_window();
  endfunction

  // An axis with no samples (hi below lo) counts as narrow
  function automatic logic narrow_span(input logic [COORD_W-1:0] lo,
                                       input logic [COORD_W-1:0] hi);
    return (hi < lo) || ((hi - lo) <= span_lim);
  endfunction

  function automatic logic [GEST_W-1:0] classify_stroke();
    logic [COORD_W-1:0] travel;
    travel = (y_last >= y_first) ? y_last - y_first : y_first - y_last;
    if (narrow_span(lo_x, hi_x) && travel > travel_lim) return GEST_VERTICAL;
    if (narrow_span(lo_y, hi_y)) return GEST_HORIZONTAL;
    if (travel < travel_lim) return GEST_V_SHAPE;
    if (x_first < x_second) return GEST_RIGHT_DIAG;
    return GEST_LEFT_DIAG;
  endfunction

  // Advance the predictor by one accepted event beat
  function automatic void apply_event(input logic [CMD_W-1:0] cmd,
                                      input logic [COORD_W-1:0] val,
                                      input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] dt;
    gesture_beat_t beat;
    case (cmd)
      CMD_LEFT, CMD_RIGHT: begin
        dt = t - last_btn_t;
        if (clicks != 0 && !armed && dt > gap_lim) clicks = '0;
        if (val != 0) begin
          if (armed) begin
            beat.gesture   = classify_stroke();
            beat.x_samples = x_cnt;
            beat.y_samples = y_cnt;
            pending_gestures.push_back(beat);
            clicks = '0;
            armed  = 1'b0;
            clear_window();
          end else if (cmd == CMD_LEFT) begin
            clicks = clicks + CLICK_W'(1);
            if (clicks == CLICKS_TO_ARM) begin
              armed = 1'b1;
              clear_window();
            end
          end else begin
            clicks = '0;
          end
        end
        last_btn_t = t;
      end
      CMD_KEY: begin
        if (!armed) clicks = '0;
      end
      CMD_POS_X: begin
        if (armed && x_cnt < WINDOW) begin
          if (x_cnt == 0) x_first = val;
          else if (x_cnt == 1) x_second = val;
          if (val < lo_x) lo_x = val;
          if (val > hi_x) hi_x = val;
          x_cnt = x_cnt + CNT_W'(1);
        end
      end
      CMD_POS_Y: begin
        if (armed) begin
          if (y_cnt < WINDOW) begin
            if (y_cnt == 0) y_first = val;
            if (val < lo_y) lo_y = val;
            if (val > hi_y) hi_y = val;
            y_cnt = y_cnt + CNT_W'(1);
          end
          y_last = val;
        end
      end
      default: ;
    endcase
  endfunction

  // Result side: check each accepted beat, then drive ready for the next edge
  always @(posedge clk) begin : gesture_check
    gesture_beat_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_gestures.size() == 0) begin
        gesture_errors++;
        $display("%0t unexpected gesture beat: expected none, got gesture %0d x %0d y %0d",
                 $time, res_ch.gesture, res_ch.x_samples, res_ch.y_samples);
      end else begin
        want = pending_gestures.pop_front();
        if (res_ch.gesture !== want.gesture || res_ch.x_samples !== want.x_samples ||
            res_ch.y_samples !== want.y_samples) begin
          gesture_errors++;
          $display({"%0t gesture mismatch: expected gesture %0d x %0d y %0d,",
                    " got gesture %0d x %0d y %0d"},
                   $time, want.gesture, want.x_samples, want.y_samples,
                   res_ch.gesture, res_ch.x_samples, res_ch.y_samples);
        end
      end
    end
    if (holdoff_done < holdoff_cycles_req) begin
      res_ch.ready <= 1'b0;
      holdoff_done++;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offer one event beat, with random idle cycles ahead of it
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] val,
                            input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid       <= 1'b1;
    evt_ch.command     <= cmd;
    evt_ch.event_value <= val;
    evt_ch.time_sec    <= t;
    do @(posedge clk); while (!evt_ch.ready);
    apply_event(cmd, val, t);
    events_sent++;
  endtask

  // Stop offering events and wait until every gesture has come out
  task automatic drain_events();
    evt_ch.valid <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no toggle
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (addr)
      REG_NARROW_SPAN: span_lim = data;
      REG_VERT_TRAVEL: travel_lim = data;
      REG_CLICK_GAP:   gap_lim = data[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input logic [COORD_W-1:0] span,
                                   input logic [COORD_W-1:0] travel,
                                   input logic [GAP_W-1:0] gap);
    drain_events();
    write_register(REG_NARROW_SPAN, span);
    write_register(REG_VERT_TRAVEL, travel);
    // upper byte is junk the register must drop
    write_register(REG_CLICK_GAP, {8'($urandom), gap});
    write_register(REG_SPARE, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
  endtask

  function automatic logic [COORD_W-1:0] pick_press_value();
    case ($urandom_range(3))
      0: return 16'h0001;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Next button time: same second, exactly the allowed gap, or anything within it
  function automatic void advance_within_gap();
    case ($urandom_range(3))
      0: ;
      1: now_t = now_t + gap_lim;
      default: now_t = now_t + $urandom_range(gap_lim);
    endcase
  endfunction

  // Coordinate spread: well inside, at, just past, or anywhere around the line limit
  function automatic int pick_span();
    int lim;
    lim = span_lim;
    case ($urandom_range(3))
      0: return $urandom_range(lim / 2);
      1: return lim;
      2: return (lim == 65535) ? lim : lim + 1;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int pick_count();
    return ($urandom_range(4) == 0) ? $urandom_range(45, 30) : $urandom_range(8);
  endfunction

  // Samples for one axis; the extremes land inside the sampling window
  function automatic void fill_axis(input int axis, input int n);
    int range, base, hi_idx;
    range = pick_span();
    base  = $urandom_range(65535 - range);
    for (int k = 0; k < n; k++) stroke_pts[axis][k] = COORD_W'(base + $urandom_range(range));
    if (n >= 2) begin
      hi_idx = ((n < WINDOW) ? n : WINDOW) - 1;
      stroke_pts[axis][$urandom_range(hi_idx)] = COORD_W'(base);
      stroke_pts[axis][$urandom_range(hi_idx)] = COORD_W'(base + range);
    end
  endfunction

  // Beats that leave a running stroke alone
  task automatic send_recording_noise();
    logic [CMD_W-1:0] cmd;
    case ($urandom_range(2))
      0: send_event(CMD_KEY, 16'($urandom), $urandom);
      1: send_event($urandom_range(1) ? CMD_LEFT : CMD_RIGHT, 16'h0000, $urandom);
      default: begin
        cmd = CMD_W'($urandom_range(CMD_NONE_HI, CMD_NONE_LO));
        send_event(cmd, 16'($urandom), $urandom);
      end
    endcase
  endtask

  // One stroke: optional noise and a broken click run, arming, samples, end press
  task automatic play_stroke();
    int n_x, n_y, xi, yi;
    logic [COORD_W-1:0] off;
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(4, 1)) send_event(CMD_W'($urandom), 16'($urandom), $urandom);
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(2, 1)) begin
        advance_within_gap();
        send_event(CMD_LEFT, pick_press_value(), now_t);
      end
      case ($urandom_range(2))
        0: send_event(CMD_RIGHT, pick_press_value(), now_t);
        1: send_event(CMD_KEY, 16'($urandom), now_t);
        default: begin
          now_t = now_t + gap_lim + 1 + ($urandom_range(1) ? 0 : $urandom_range(100000));
          send_event(CMD_LEFT, 16'h0000, now_t);
        end
      endcase
    end
    repeat (CLICKS_TO_ARM) begin
      if ($urandom_range(2) == 0) begin
        advance_within_gap();
        send_event(CMD_LEFT, 16'h0000, now_t);
      end
      advance_within_gap();
      send_event(CMD_LEFT, pick_press_value(), now_t);
    end
    n_x = pick_count();
    n_y = pick_count();
    fill_axis(0, n_x);
    fill_axis(1, n_y);
    // pull the last Y near the first one around the travel limit
    if (n_y >= 1 && $urandom_range(1)) begin
      case ($urandom_range(3))
        0: off = travel_lim;
        1: off = travel_lim + 1'b1;
        2: off = travel_lim - 1'b1;
        default: off = COORD_W'($urandom_range(travel_lim));
      endcase
      stroke_pts[1][n_y-1] = $urandom_range(1) ? stroke_pts[1][0] + off : stroke_pts[1][0] - off;
    end
    xi = 0;
    yi = 0;
    while (xi < n_x || yi < n_y) begin
      if ($urandom_range(11) == 0) begin
        send_recording_noise();
      end else if (yi >= n_y || (xi < n_x && $urandom_range(1))) begin
        send_event(CMD_POS_X, stroke_pts[0][xi], $urandom);
        xi++;
      end else begin
        send_event(CMD_POS_Y, stroke_pts[1][yi], $urandom);
        yi++;
      end
    end
    if ($urandom_range(3) == 0) send_event(CMD_RIGHT, 16'h0000, $urandom);
    now_t = now_t + $urandom_range(3);
    send_event($urandom_range(1) ? CMD_LEFT : CMD_RIGHT, pick_press_value(), now_t);
  endtask

  task automatic run_strokes(input int n_events);
    int target;
    target = events_sent + n_events;
    while (events_sent < target) play_stroke();
  endtask

  // Hand-picked beats: ignored commands, click-run breakers, gap, wrap, extremes
  task automatic test_directed_events();
    send_event(CMD_NONE_HI, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(CMD_NONE_LO, 16'h0000, 32'h0000_0000);
    send_event(CMD_POS_X, 16'hFFFF, 32'd0);        // idle positions are dropped
    send_event(CMD_POS_Y, 16'h0000, 32'd0);
    send_event(CMD_LEFT, 16'h0001, 32'd0);
    send_event(CMD_RIGHT, 16'hFFFF, 32'd0);        // right press clears the run
    send_event(CMD_LEFT, 16'h0001, 32'd0);
    send_event(CMD_KEY, 16'h8000, 32'd0);          // key clears the run
    send_event(CMD_LEFT, 16'h0001, 32'd10);
    send_event(CMD_LEFT, 16'h0000, 32'd10);        // release only moves the time
    send_event(CMD_LEFT, 16'h0001, 32'd12);        // gap too long, run restarts
    send_event(CMD_LEFT, 16'h0001, 32'd13);
    send_event(CMD_LEFT, 16'h0001, 32'd13);        // armed
    send_event(CMD_RIGHT, 16'h0001, 32'd14);       // stroke with no samples
    send_event(CMD_LEFT, 16'h0001, 32'hFFFF_FFFE);
    send_event(CMD_LEFT, 16'h0001, 32'hFFFF_FFFF);
    send_event(CMD_LEFT, 16'hFFFF, 32'd0);         // armed across the time wrap
    send_event(CMD_POS_X, 16'h0000, 32'hFFFF_FFFF);
    send_event(CMD_POS_X, 16'hFFFF, 32'd0);
    send_event(CMD_POS_Y, 16'hFFFF, 32'd0);
    send_event(CMD_POS_Y, 16'h0000, 32'd0);
    send_event(CMD_KEY, 16'h0001, 32'd0);          // no effect while recording
    send_event(CMD_NONE_MID, 16'h5555, 32'hAAAA_AAAA);
    send_event(CMD_LEFT, 16'h0000, 32'd7);
    send_event(CMD_LEFT, 16'h8000, 32'd40);        // ends the stroke
    now_t = $urandom;
  endtask

  task automatic test_register_extremes();
    program_registers(16'h0000, 16'h0000, 8'h00);
    run_strokes(200);
    program_registers(16'hFFFF, 16'hFFFF, 8'hFF);
    run_strokes(200);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      program_registers(16'($urandom_range(20000)), 16'($urandom_range(6000)),
                        8'($urandom_range(4)));
      run_strokes(250);
    end
  endtask

  task automatic test_steady_stream();
    program_registers(NARROW_SPAN_RST, VERT_TRAVEL_RST, CLICK_GAP_RST);
    run_strokes(500);
  endtask

  // Receiver stalls while short strokes keep coming, so the output fills up
  task automatic test_output_holdoff();
    drain_events();
    holdoff_cycles_req <= HOLDOFF_CYCLES;
    repeat (8) begin
      repeat (CLICKS_TO_ARM) send_event(CMD_LEFT, pick_press_value(), now_t);
      send_event(CMD_RIGHT, pick_press_value(), now_t);
    end
  endtask

  initial begin
    reset_model();
    now_t               = '0;
    rst                <= 1'b1;
    evt_ch.valid       <= 1'b0;
    evt_ch.command     <= CMD_LEFT;
    evt_ch.event_value <= '0;
    evt_ch.time_sec    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= REG_NARROW_SPAN;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_idling(33, 67);
    test_directed_events();
    test_register_extremes();
    set_idling(67, 33);
    test_random_settings();
    set_idling(0, 0);
    test_steady_stream();
    test_output_holdoff();
    drain_events();

    if (gesture_errors == 0) begin
      $display("[triple_click_gesture_classifier] OK");
    end else begin
      $display("[triple_click_gesture_classifier] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[triple_click_gesture_classifier] ERROR");
    $finish;
  end

endmodule
